>>> rtl/dual_receiver_fix_selector_defines.svh
// Assertion macros shared by the dual receiver fix selector RTL.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef DUAL_RECEIVER_FIX_SELECTOR_DEFINES_SVH
`define DUAL_RECEIVER_FIX_SELECTOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock outside reset
`define DRFS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock outside reset
`define DRFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/dfs_pkg.sv
// Package for the dual receiver fix selector: widths, codes, reset values
// and the structs passed between the top level and the decision logic.
package dfs_pkg;

   // Field widths
   localparam int unsigned ID_W    = 8;
   localparam int unsigned FIX_W   = 3;
   localparam int unsigned SATS_W  = 8;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned STALE_W = 8;
   localparam int unsigned HOLD_W  = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   typedef logic [MODE_W-1:0]     mode_type;
   typedef logic [CSR_IDX_W-1:0]  csr_index_type;

   // Selection modes (code 3 behaves as automatic)
   localparam mode_type MODE_PRIMARY   = 2'd0;
   localparam mode_type MODE_SECONDARY = 2'd1;
   localparam mode_type MODE_AUTO      = 2'd2;

   // Operation codes
   localparam logic OP_REPORT = 1'b0;
   localparam logic OP_CHECK  = 1'b1;

   // Fix codes
   localparam logic [FIX_W-1:0] FIX_NONE = 3'd0;
   localparam logic [FIX_W-1:0] FIX_3D   = 3'd3;

   // Register indexes
   localparam csr_index_type CSR_SELECT_MODE = 3'd0;
   localparam csr_index_type CSR_PRIMARY_ID  = 3'd1;
   localparam csr_index_type CSR_SECONDARY_ID = 3'd2;
   localparam csr_index_type CSR_OWN_SENDER  = 3'd3;
   localparam csr_index_type CSR_STALE_LIMIT = 3'd4;
   localparam csr_index_type CSR_HOLDOFF     = 3'd5;

   // Register reset values
   localparam mode_type            MODE_RESET      = MODE_AUTO;
   localparam logic [ID_W-1:0]     PRIMARY_RESET   = 8'd0;
   localparam logic [ID_W-1:0]     SECONDARY_RESET = 8'd1;
   localparam logic [ID_W-1:0]     OWN_RESET       = 8'd255;
   localparam logic [STALE_W-1:0]  STALE_RESET     = 8'd2;
   localparam logic [HOLD_W-1:0]   HOLDOFF_RESET   = 16'd5000;

   typedef struct packed {
      mode_type             select_mode;
      logic [ID_W-1:0]      primary_id;
      logic [ID_W-1:0]      secondary_id;
      logic [ID_W-1:0]      own_sender_id;
      logic [STALE_W-1:0]   stale_limit_sec;
      logic [HOLD_W-1:0]    holdoff_ms;
   } cfg_type;

   typedef struct packed {
      logic                 operation;
      logic [ID_W-1:0]      src_id;
      logic [ID_W-1:0]      rx_id;
      logic [FIX_W-1:0]     fix_kind;
      logic [SATS_W-1:0]    sat_count;
      logic [TIME_W-1:0]    now_ms;
      logic [TIME_W-1:0]    now_sec;
      logic [TIME_W-1:0]    last_msg_sec;
   } item_type;

   typedef struct packed {
      logic [ID_W-1:0]      chosen_receiver;
      logic [TIME_W-1:0]    last_switch_ms;
      logic [FIX_W-1:0]     held_fix;
      logic [SATS_W-1:0]    held_sat_count;
      logic [ID_W-1:0]      held_receiver;
   } state_type;

   typedef struct packed {
      state_type            state_next;
      logic                 run;
      logic                 taken;
      logic                 republish;
   } decision_type;

endpackage

>>> rtl/dfs_decide.sv
// Decision logic of the dual receiver fix selector: staleness, own-report
// filter, receiver pick and held solution update. Depends on dfs_pkg.
module dfs_decide (
   input  dfs_pkg::cfg_type      cfg,
   input  dfs_pkg::state_type    state,
   input  dfs_pkg::item_type     item,
   output dfs_pkg::decision_type dec
);
   import dfs_pkg::*;

   logic [TIME_W-1:0] sec_age;
   logic [TIME_W-1:0] ms_since_switch;
   logic              stale;
   logic              holdoff_ok;
   logic              run;
   logic [FIX_W-1:0]  fix_eff;
   logic [ID_W-1:0]   pick;
   logic              do_switch;
   logic              take;

   // Age checks, both modulo 2^32
   assign sec_age         = item.now_sec - item.last_msg_sec;
   assign ms_since_switch = item.now_ms - state.last_switch_ms;
   assign stale      = sec_age > {{(TIME_W-STALE_W){1'b0}}, cfg.stale_limit_sec};
   assign holdoff_ok = ms_since_switch > {{(TIME_W-HOLD_W){1'b0}}, cfg.holdoff_ms};

   // A check may drop the fix; a report of our own is ignored
   assign fix_eff = (item.operation == OP_CHECK && stale) ? FIX_NONE : item.fix_kind;
   assign run     = (item.operation == OP_CHECK) || (item.src_id != cfg.own_sender_id);

   // Receiver pick
   always_comb begin
      do_switch = 1'b0;
      pick      = state.chosen_receiver;
      case (cfg.select_mode)
         MODE_PRIMARY: begin
            pick = cfg.primary_id;
         end
         MODE_SECONDARY: begin
            pick = cfg.secondary_id;
         end
         default: begin
            if (fix_eff > state.held_fix) begin
               pick = item.rx_id;
            end else if (state.held_fix > fix_eff) begin
               pick = state.held_receiver;
            end else if (holdoff_ok) begin
               // equal fix: more satellites wins after the hold-off
               if (item.sat_count > state.held_sat_count) begin
                  pick      = item.rx_id;
                  do_switch = 1'b1;
               end else if (state.held_sat_count > item.sat_count) begin
                  pick      = state.held_receiver;
                  do_switch = 1'b1;
               end
            end
         end
      endcase
   end

   assign take = run && (item.rx_id == pick);

   // Next state and flags
   always_comb begin
      dec.state_next = state;
      if (run) begin
         dec.state_next.chosen_receiver = pick;
      end
      if (run && do_switch) begin
         dec.state_next.last_switch_ms = item.now_ms;
      end
      if (take) begin
         dec.state_next.held_fix       = fix_eff;
         dec.state_next.held_sat_count = item.sat_count;
         dec.state_next.held_receiver  = item.rx_id;
      end
      dec.run       = run;
      dec.taken     = take;
      dec.republish = take && (item.operation == OP_REPORT);
   end

endmodule

>>> rtl/dual_receiver_fix_selector.sv
// Top level of the dual receiver fix selector: input word register, state,
// result register and configuration registers. Depends on dfs_pkg, dfs_decide
// and dual_receiver_fix_selector_defines.svh.
//
//   channel  direction  handshake               payload
//   req_     in         req_valid / req_stall   operation .. last_msg_sec
//   rsp_     out        rsp_valid / rsp_stall   chosen_id .. fix_valid
//   csr_     in         csr_valid / csr_ready   csr_index, csr_wdata
//
// One word per cycle sustained while rsp_stall is low; an accepted word passes through the input register,
// then the decision and state update into the result register.
// The state update of one word feeds the next in the following cycle.
// Reset is synchronous and active high; configuration, state and valid registers take their listed reset values.
// rsp_stall holds the result register; the input register still fills behind
// it, and req_stall rises only when both are occupied. csr_ready is always high.
module dual_receiver_fix_selector (
   input  logic                           clock,
   input  logic                           reset,
   // input words
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_operation,
   input  logic [7:0]                     req_src_id,
   input  logic [7:0]                     req_rx_id,
   input  logic [2:0]                     req_fix_kind,
   input  logic [7:0]                     req_sat_count,
   input  logic [31:0]                    req_now_ms,
   input  logic [31:0]                    req_now_sec,
   input  logic [31:0]                    req_last_msg_sec,
   // result words
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_chosen_id,
   output logic                           rsp_taken,
   output logic                           rsp_republish,
   output logic [2:0]                     rsp_current_fix,
   output logic                           rsp_fix_valid,
   // configuration writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  dfs_pkg::csr_index_type         csr_index,
   input  logic [dfs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dfs_pkg::*;
   `include "dual_receiver_fix_selector_defines.svh"

   cfg_type              cfg_ff,       cfg_in;
   item_type             item_ff,      item_in;
   logic                 in_valid_ff,  in_valid_in;
   state_type            state_ff,     state_in;
   logic                 out_valid_ff, out_valid_in;
   logic [ID_W-1:0]      chosen_ff,    chosen_in;
   logic                 taken_ff,     taken_in;
   logic                 repub_ff,     repub_in;
   logic [FIX_W-1:0]     fix_ff,       fix_in;
   decision_type         dec;
   logic                 advance;
   logic                 req_take;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SELECT_MODE:  cfg_in.select_mode     = csr_wdata[MODE_W-1:0];
            CSR_PRIMARY_ID:   cfg_in.primary_id      = csr_wdata[ID_W-1:0];
            CSR_SECONDARY_ID: cfg_in.secondary_id    = csr_wdata[ID_W-1:0];
            CSR_OWN_SENDER:   cfg_in.own_sender_id   = csr_wdata[ID_W-1:0];
            CSR_STALE_LIMIT:  cfg_in.stale_limit_sec = csr_wdata[STALE_W-1:0];
            CSR_HOLDOFF:      cfg_in.holdoff_ms      = csr_wdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: the input word moves on when the result register is free
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // Input word register
   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !advance);
      item_in     = item_ff;
      if (req_take) begin
         item_in.operation    = req_operation;
         item_in.src_id       = req_src_id;
         item_in.rx_id        = req_rx_id;
         item_in.fix_kind     = req_fix_kind;
         item_in.sat_count    = req_sat_count;
         item_in.now_ms       = req_now_ms;
         item_in.now_sec      = req_now_sec;
         item_in.last_msg_sec = req_last_msg_sec;
      end
   end

   dfs_decide u_decide (
      .cfg   (cfg_ff),
      .state (state_ff),
      .item  (item_ff),
      .dec   (dec)
   );

   // State and result register
   always_comb begin
      state_in     = advance ? dec.state_next : state_ff;
      out_valid_in = advance || (out_valid_ff && rsp_stall);
      chosen_in    = chosen_ff;
      taken_in     = taken_ff;
      repub_in     = repub_ff;
      fix_in       = fix_ff;
      if (advance) begin
         chosen_in = dec.state_next.chosen_receiver;
         taken_in  = dec.taken;
         repub_in  = dec.republish;
         fix_in    = dec.state_next.held_fix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.select_mode     <= MODE_RESET;
         cfg_ff.primary_id      <= PRIMARY_RESET;
         cfg_ff.secondary_id    <= SECONDARY_RESET;
         cfg_ff.own_sender_id   <= OWN_RESET;
         cfg_ff.stale_limit_sec <= STALE_RESET;
         cfg_ff.holdoff_ms      <= HOLDOFF_RESET;
         state_ff.chosen_receiver <= PRIMARY_RESET;
         state_ff.last_switch_ms  <= '0;
         state_ff.held_fix        <= FIX_NONE;
         state_ff.held_sat_count  <= '0;
         state_ff.held_receiver   <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      chosen_ff <= chosen_in;
      taken_ff  <= taken_in;
      repub_ff  <= repub_in;
      fix_ff    <= fix_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_chosen_id   = chosen_ff;
   assign rsp_taken       = taken_ff;
   assign rsp_republish   = repub_ff;
   assign rsp_current_fix = fix_ff;
   assign rsp_fix_valid   = (fix_ff >= FIX_3D);

   // Checks
   `DRFS_ASSERT_NOW(a_repub_taken, clock, reset, rsp_valid && rsp_republish, rsp_taken, "republish without take")
   `DRFS_ASSERT_NEXT(a_taken_held, clock, reset, advance && dec.taken, state_ff.held_receiver == state_ff.chosen_receiver, "taken word not held as chosen")
   `DRFS_ASSERT_NEXT(a_held_word, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(item_ff), "input word lost while blocked")
   `DRFS_ASSERT_NEXT(a_forced_primary, clock, reset, advance && dec.run && cfg_ff.select_mode == MODE_PRIMARY, state_ff.chosen_receiver == $past(cfg_ff.primary_id), "forced primary not chosen")
   `DRFS_ASSERT_NEXT(a_result_kept, clock, reset, out_valid_ff && rsp_stall, out_valid_ff && $stable(chosen_ff) && $stable(fix_ff), "stalled result overwritten")

endmodule
